### rtl/core/bsds_pkg.sv
package bsds_pkg;

    localparam int SOC_W  = 7;
    localparam int LIM_W  = 8;
    localparam int MV_W   = 16;
    localparam int RTC_W  = 32;
    localparam int LVC_W  = 3;

    localparam logic [SOC_W-1:0] SOC_MAX        = 7'd100;
    localparam logic [SOC_W-1:0] TIER_HIGH      = 7'd95;
    localparam logic [SOC_W-1:0] TIER_MID       = 7'd60;
    localparam logic [SOC_W-1:0] OCV_FULL_GAUGE = 7'd90;
    localparam logic [SOC_W-1:0] OCV_FLOOR_IDX  = 7'd2;
    localparam logic [MV_W-1:0]  LOW_VOLT_MV    = 16'd3300;
    localparam logic [MV_W-1:0]  ZERO_VOLT_MV   = 16'd3400;
    localparam logic [LVC_W-1:0] ZERO_TICKS     = 3'd5;

    // register reset values
    localparam logic [SOC_W-1:0] RST_DEFAULT_SOC         = 7'd50;
    localparam logic [LIM_W-1:0] RST_UP_LIMIT_FULL       = 8'd6;
    localparam logic [LIM_W-1:0] RST_UP_LIMIT_CHARGING   = 8'd3;
    localparam logic [LIM_W-1:0] RST_DOWN_LIMIT_AT_FULL  = 8'd30;
    localparam logic [LIM_W-1:0] RST_DOWN_LIMIT_HIGH     = 8'd15;
    localparam logic [LIM_W-1:0] RST_DOWN_LIMIT_MID      = 8'd6;
    localparam logic [LIM_W-1:0] RST_DOWN_LIMIT_LOW      = 8'd4;
    localparam logic [LIM_W-1:0] RST_DOWN_LIMIT_LOW_VOLT = 8'd2;

    typedef enum logic [2:0] {
        CFG_DEFAULT_SOC,
        CFG_UP_LIMIT_FULL,
        CFG_UP_LIMIT_CHARGING,
        CFG_DOWN_LIMIT_AT_FULL,
        CFG_DOWN_LIMIT_HIGH,
        CFG_DOWN_LIMIT_MID,
        CFG_DOWN_LIMIT_LOW,
        CFG_DOWN_LIMIT_LOW_VOLT
    } t_cfg_idx;

    typedef struct packed {
        logic [SOC_W-1:0] default_soc;
        logic [LIM_W-1:0] up_limit_full;
        logic [LIM_W-1:0] up_limit_charging;
        logic [LIM_W-1:0] down_limit_at_full;
        logic [LIM_W-1:0] down_limit_high;
        logic [LIM_W-1:0] down_limit_mid;
        logic [LIM_W-1:0] down_limit_low;
        logic [LIM_W-1:0] down_limit_low_volt;
    } t_cfg;

    typedef struct packed {
        logic             gauge_available;
        logic [SOC_W-1:0] gauge_soc;
        logic             charger_present;
        logic             battery_full;
        logic             battery_authentic;
        logic             battery_present;
        logic             temp_normal;
        logic             is_charging;
        logic             suspended;
        logic [MV_W-1:0]  voltage_mv;
        logic [RTC_W-1:0] rtc_seconds;
        logic             rtc_ok;
    } t_in;

    typedef struct packed {
        logic [SOC_W-1:0] display_soc;
        logic [SOC_W-1:0] ocv_index;
        logic             ocv_updated;
        logic             pre_full;
    } t_out;

    typedef struct packed {
        logic             started;
        logic [SOC_W-1:0] shown_soc;
        logic [LIM_W-1:0] rise_count;
        logic [LIM_W-1:0] fall_count;
        logic [LVC_W-1:0] low_volt_count;
        logic [RTC_W-1:0] last_update_time;
        logic             full_mark;
    } t_state;

endpackage

### rtl/core/bsds_ifs.sv
interface bsds_in_if;
    import bsds_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface bsds_out_if;
    import bsds_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface bsds_cfg_if;
    import bsds_pkg::*;
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [LIM_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/core/battery_soc_display_smoother.sv
// channel   modport  transaction
// i_in      sink     one tick: gauge soc, charger/battery flags, voltage, rtc
// o_out     source   one result per tick: display soc, ocv index, flags
// i_cfg     sink     register write: index and 8-bit data, always ready
//
// one tick per cycle sustained while o_out is ready; a result is offered once the tick
// has passed the input register and then the result register behind the update logic
// i_rst_n is synchronous: clears both stages and the smoothing state, resets the registers
// a stalled o_out holds its result; the input register still fills behind it
// and i_in.ready drops only when both stages are occupied
module battery_soc_display_smoother #(
    parameter int SUSPEND_GAP_SECONDS = 480
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsds_in_if.sink   i_in,
    bsds_out_if.source o_out,
    bsds_cfg_if.sink  i_cfg
);
    import bsds_pkg::*;

    t_cfg   w_cfg;
    t_state r_state;
    t_state n_state;
    t_out   n_out;
    t_out   r_out;
    t_in    r_s1_item;
    logic   r_s1_valid;
    logic   r_out_valid;
    logic   w_adv;

    // configuration registers
    bsds_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // single-pass update from registered tick and current state
    bsds_update #(
        .SUSPEND_GAP_SECONDS (SUSPEND_GAP_SECONDS)
    ) u_update (
        .i_item  (r_s1_item),
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // result register moves when it is empty or being taken
    assign w_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_s1_valid || w_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            // state commits exactly when the tick's result is registered
            if (w_adv && r_s1_valid) begin
                r_state <= n_state;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item <= i_in.data;
        end
        if (w_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    // pre-full flag is sticky once set
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.full_mark |=> r_state.full_mark)
        else $error("full mark cleared");

    // low-voltage tick count saturates at the zero threshold
    a_lvc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.low_volt_count <= ZERO_TICKS)
        else $error("low voltage count out of range");

    // a tick in the input stage is kept while the result side is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("input stage lost while stalled");

    // state only changes when a result is registered
    a_state_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && r_s1_valid) |=> $stable(r_state))
        else $error("state changed without a result");

endmodule

### rtl/core/bsds_cfg_regs.sv
module bsds_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bsds_cfg_if.sink        i_cfg,
    output bsds_pkg::t_cfg  o_cfg
);
    import bsds_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_soc         <= RST_DEFAULT_SOC;
            r_cfg.up_limit_full       <= RST_UP_LIMIT_FULL;
            r_cfg.up_limit_charging   <= RST_UP_LIMIT_CHARGING;
            r_cfg.down_limit_at_full  <= RST_DOWN_LIMIT_AT_FULL;
            r_cfg.down_limit_high     <= RST_DOWN_LIMIT_HIGH;
            r_cfg.down_limit_mid      <= RST_DOWN_LIMIT_MID;
            r_cfg.down_limit_low      <= RST_DOWN_LIMIT_LOW;
            r_cfg.down_limit_low_volt <= RST_DOWN_LIMIT_LOW_VOLT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEFAULT_SOC:         r_cfg.default_soc <= i_cfg.data[SOC_W-1:0];
                CFG_UP_LIMIT_FULL:       r_cfg.up_limit_full <= i_cfg.data;
                CFG_UP_LIMIT_CHARGING:   r_cfg.up_limit_charging <= i_cfg.data;
                CFG_DOWN_LIMIT_AT_FULL:  r_cfg.down_limit_at_full <= i_cfg.data;
                CFG_DOWN_LIMIT_HIGH:     r_cfg.down_limit_high <= i_cfg.data;
                CFG_DOWN_LIMIT_MID:      r_cfg.down_limit_mid <= i_cfg.data;
                CFG_DOWN_LIMIT_LOW:      r_cfg.down_limit_low <= i_cfg.data;
                CFG_DOWN_LIMIT_LOW_VOLT: r_cfg.down_limit_low_volt <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/core/bsds_update.sv
module bsds_update #(
    parameter int SUSPEND_GAP_SECONDS = 480
) (
    input  bsds_pkg::t_in    i_item,
    input  bsds_pkg::t_state i_state,
    input  bsds_pkg::t_cfg   i_cfg,
    output bsds_pkg::t_state o_state,
    output bsds_pkg::t_out   o_res
);
    import bsds_pkg::*;

    localparam logic [RTC_W-1:0] GAP = RTC_W'(SUSPEND_GAP_SECONDS);

    logic             full_cond;
    logic             chg_cond;
    logic [SOC_W-1:0] g_sat;
    logic [SOC_W-1:0] dflt_sat;
    logic [SOC_W-1:0] s_full;
    logic [SOC_W-1:0] s_br;
    logic [SOC_W-1:0] s_drop;
    logic [SOC_W-1:0] s_fin;
    logic [SOC_W-1:0] idx;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] rise_n;
    logic [LIM_W-1:0] fall_n;
    logic [LVC_W-1:0] lvc_n;
    logic [RTC_W-1:0] gap;
    logic             susp_drop;

    always_comb begin
        g_sat     = (i_item.gauge_soc > SOC_MAX) ? SOC_MAX : i_item.gauge_soc;
        dflt_sat  = (i_cfg.default_soc > SOC_MAX) ? SOC_MAX : i_cfg.default_soc;
        full_cond = i_item.charger_present && i_item.battery_full &&
                    i_item.battery_authentic && i_item.battery_present &&
                    i_item.temp_normal;
        chg_cond  = i_item.charger_present && i_item.is_charging && i_item.battery_present;
        gap       = i_item.rtc_seconds - i_state.last_update_time;
        susp_drop = i_item.suspended && i_item.rtc_ok && (gap >= GAP);

        // full branch step
        if (i_state.rise_count >= i_cfg.up_limit_full) begin
            s_full = i_state.shown_soc + 7'd1;
        end else begin
            s_full = i_state.shown_soc;
        end

        // charge / discharge branch
        s_br   = i_state.shown_soc;
        rise_n = i_state.rise_count;
        fall_n = i_state.fall_count;
        s_drop = i_state.shown_soc;
        lim    = i_cfg.down_limit_low;
        if (chg_cond) begin
            fall_n = '0;
            if (g_sat > i_state.shown_soc) begin
                if (i_state.rise_count >= i_cfg.up_limit_charging) begin
                    rise_n = '0;
                    s_br   = i_state.shown_soc + 7'd1;
                end else begin
                    rise_n = i_state.rise_count + 8'd1;
                end
            end
        end else begin
            rise_n = '0;
            if (g_sat < i_state.shown_soc) begin
                // extra drop after a long suspend gap
                s_drop = susp_drop ? (i_state.shown_soc - 7'd1) : i_state.shown_soc;
                if (s_drop == SOC_MAX) begin
                    lim = i_cfg.down_limit_at_full;
                end else if (s_drop >= TIER_HIGH) begin
                    lim = i_cfg.down_limit_high;
                end else if (s_drop >= TIER_MID) begin
                    lim = i_cfg.down_limit_mid;
                end else begin
                    lim = i_cfg.down_limit_low;
                end
                if ((i_item.voltage_mv < LOW_VOLT_MV) && i_item.battery_present) begin
                    lim = i_cfg.down_limit_low_volt;
                end
                s_br = s_drop;
                if (i_state.fall_count >= lim) begin
                    fall_n = '0;
                    if (s_drop > 7'd1) begin
                        s_br = s_drop - 7'd1;
                    end
                end else begin
                    fall_n = i_state.fall_count + 8'd1;
                end
            end
        end

        // range clamp, zero only after enough low-voltage ticks
        lvc_n = i_state.low_volt_count;
        if (s_br >= SOC_MAX) begin
            s_fin = SOC_MAX;
        end else if (s_br < 7'd2) begin
            if (!i_item.battery_present) begin
                s_fin = 7'd1;
            end else begin
                if (i_item.voltage_mv < ZERO_VOLT_MV) begin
                    if (i_state.low_volt_count < ZERO_TICKS) begin
                        lvc_n = i_state.low_volt_count + 3'd1;
                    end
                end else begin
                    lvc_n = '0;
                end
                s_fin = (lvc_n >= ZERO_TICKS) ? 7'd0 : 7'd1;
            end
        end else begin
            s_fin = s_br;
        end

        if (s_fin <= OCV_FLOOR_IDX) begin
            idx = OCV_FLOOR_IDX;
        end else if ((s_fin == SOC_MAX) && (g_sat > OCV_FULL_GAUGE)) begin
            idx = SOC_MAX;
        end else begin
            idx = s_fin - 7'd1;
        end

        o_state = i_state;
        o_res   = '0;
        if (!i_item.gauge_available) begin
            o_res.display_soc = dflt_sat;
            o_res.pre_full    = i_state.full_mark;
        end else if (!i_state.started) begin
            o_state.started   = 1'b1;
            o_state.shown_soc = g_sat;
            o_res.display_soc = g_sat;
            o_res.pre_full    = i_state.full_mark;
        end else if (full_cond) begin
            o_state.fall_count = '0;
            o_state.rise_count = (i_state.rise_count >= i_cfg.up_limit_full) ?
                                 '0 : (i_state.rise_count + 8'd1);
            if (s_full >= SOC_MAX) begin
                o_state.shown_soc = SOC_MAX;
                o_state.full_mark = 1'b1;
            end else begin
                o_state.shown_soc = s_full;
            end
            o_res.display_soc = o_state.shown_soc;
            o_res.ocv_index   = o_state.shown_soc;
            o_res.ocv_updated = 1'b1;
            o_res.pre_full    = o_state.full_mark;
        end else begin
            o_state.shown_soc      = s_fin;
            o_state.rise_count     = rise_n;
            o_state.fall_count     = fall_n;
            o_state.low_volt_count = lvc_n;
            if (i_item.rtc_ok) begin
                o_state.last_update_time = i_item.rtc_seconds;
            end
            o_res.display_soc = s_fin;
            o_res.ocv_index   = idx;
            o_res.ocv_updated = 1'b1;
            o_res.pre_full    = i_state.full_mark;
        end
    end

endmodule

### test/battery_soc_display_smoother_tb.sv
module battery_soc_display_smoother_tb;
    import bsds_pkg::*;

    localparam int SUSPEND_GAP = 480;
    localparam int HOLD_CYCLES = 64;    // long receiver hold-off, fills both stages
    localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction before giving up
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 160;

    typedef enum {SCN_FULL, SCN_CHARGE, SCN_DRAIN, SCN_NOISE} t_scene;
    typedef enum {RX_FREE, RX_RANDOM, RX_STRETCH} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    bsds_in_if  in_if();
    bsds_out_if out_if();
    bsds_cfg_if cfg_if();

    battery_soc_display_smoother #(
        .SUSPEND_GAP_SECONDS(SUSPEND_GAP)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // ticks waiting to be offered, and readouts the smoother owes us
    t_in  tick_queue[$];
    t_out pending_readouts[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // traffic shaping knobs, changed only at the falling edge
    bit       tx_gaps      = 1'b1;
    t_rx_mode rx_mode      = RX_FREE;
    int       hold_trigger = 0;

    // shadow copy of the smoothing state
    bit          tick_started   = 1'b0;
    int          soc_shown      = 0;
    int          rise_ticks     = 0;
    int          fall_ticks     = 0;
    int          low_volt_ticks = 0;
    logic [31:0] last_rtc       = '0;
    bit          full_seen      = 1'b0;

    // shadow copy of the registers
    logic [6:0] cfg_default       = RST_DEFAULT_SOC;
    logic [7:0] cfg_up_full       = RST_UP_LIMIT_FULL;
    logic [7:0] cfg_up_chg        = RST_UP_LIMIT_CHARGING;
    logic [7:0] cfg_down_full     = RST_DOWN_LIMIT_AT_FULL;
    logic [7:0] cfg_down_high     = RST_DOWN_LIMIT_HIGH;
    logic [7:0] cfg_down_mid      = RST_DOWN_LIMIT_MID;
    logic [7:0] cfg_down_low      = RST_DOWN_LIMIT_LOW;
    logic [7:0] cfg_down_low_volt = RST_DOWN_LIMIT_LOW_VOLT;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // advance the shadow smoother by one tick and return what it should show
    function automatic t_out smooth_soc(t_in x);
        t_out        r;
        int          g;
        int          lim;
        logic [31:0] gap;
        r = '0;
        r.pre_full = full_seen;
        // no gauge: report the default and leave all state alone
        if (!x.gauge_available) begin
            r.display_soc = (cfg_default > SOC_MAX) ? SOC_MAX : cfg_default;
            return r;
        end
        g = (x.gauge_soc > SOC_MAX) ? int'(SOC_MAX) : int'(x.gauge_soc);
        // very first gauge tick just copies the gauge
        if (!tick_started) begin
            tick_started  = 1'b1;
            soc_shown     = g;
            r.display_soc = 7'(g);
            return r;
        end
        // full and healthy: creep up to 100, no floor clamp, rtc not stored
        if (x.charger_present && x.battery_full && x.battery_authentic &&
            x.battery_present && x.temp_normal) begin
            fall_ticks = 0;
            if (rise_ticks >= cfg_up_full) begin
                rise_ticks = 0;
                soc_shown++;
            end else begin
                rise_ticks++;
            end
            if (soc_shown >= SOC_MAX) begin
                soc_shown = int'(SOC_MAX);
                full_seen = 1'b1;
            end
            r.display_soc = 7'(soc_shown);
            r.ocv_index   = 7'(soc_shown);
            r.ocv_updated = 1'b1;
            r.pre_full    = full_seen;
            return r;
        end
        if (x.charger_present && x.is_charging && x.battery_present) begin
            fall_ticks = 0;
            if (g > soc_shown) begin
                if (rise_ticks >= cfg_up_chg) begin
                    rise_ticks = 0;
                    soc_shown++;
                end else begin
                    rise_ticks++;
                end
            end
        end else begin
            rise_ticks = 0;
            if (g < soc_shown) begin
                // long suspend gap gives one extra step down
                gap = x.rtc_seconds - last_rtc;
                if (x.suspended && x.rtc_ok && gap >= SUSPEND_GAP)
                    soc_shown--;
                if (soc_shown == SOC_MAX)
                    lim = int'(cfg_down_full);
                else if (soc_shown >= TIER_HIGH)
                    lim = int'(cfg_down_high);
                else if (soc_shown >= TIER_MID)
                    lim = int'(cfg_down_mid);
                else
                    lim = int'(cfg_down_low);
                if (x.voltage_mv < LOW_VOLT_MV && x.battery_present)
                    lim = int'(cfg_down_low_volt);
                if (fall_ticks >= lim) begin
                    fall_ticks = 0;
                    if (soc_shown > 1)
                        soc_shown--;
                end else begin
                    fall_ticks++;
                end
            end
        end
        // clamp; zero only after a run of low-voltage ticks with a battery in
        if (soc_shown >= SOC_MAX) begin
            soc_shown = int'(SOC_MAX);
        end else if (soc_shown < 2) begin
            if (x.battery_present) begin
                if (x.voltage_mv < ZERO_VOLT_MV) begin
                    if (low_volt_ticks < ZERO_TICKS)
                        low_volt_ticks++;
                end else begin
                    low_volt_ticks = 0;
                end
            end
            soc_shown = (x.battery_present && low_volt_ticks >= ZERO_TICKS) ? 0 : 1;
        end
        if (soc_shown <= 2)
            r.ocv_index = OCV_FLOOR_IDX;
        else if (soc_shown == SOC_MAX && g > OCV_FULL_GAUGE)
            r.ocv_index = SOC_MAX;
        else
            r.ocv_index = 7'(soc_shown - 1);
        // a failed rtc read keeps the old timestamp
        if (x.rtc_ok)
            last_rtc = x.rtc_seconds;
        r.display_soc = 7'(soc_shown);
        r.ocv_updated = 1'b1;
        r.pre_full    = full_seen;
        return r;
    endfunction

    function automatic t_in mk_tick(bit avail, logic [6:0] g, bit chg, bit full, bit auth,
                                    bit pres, bit tnorm, bit charging, bit susp,
                                    logic [15:0] mv, logic [31:0] rtc, bit ok);
        t_in t;
        t.gauge_available   = avail;
        t.gauge_soc         = g;
        t.charger_present   = chg;
        t.battery_full      = full;
        t.battery_authentic = auth;
        t.battery_present   = pres;
        t.temp_normal       = tnorm;
        t.is_charging       = charging;
        t.suspended         = susp;
        t.voltage_mv        = mv;
        t.rtc_seconds       = rtc;
        t.rtc_ok            = ok;
        return t;
    endfunction

    // every tick yields a readout, so an empty scoreboard means an empty pipe
    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || in_if.valid || pending_readouts.size() != 0);
    endtask

    // sender: bursts of random length, random gaps between them when tx_gaps is set
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
                in_if.data  <= tick_queue.pop_front();
                in_if.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= tx_gaps ? $urandom_range(1, 6) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: free-running, random, or stretches; a trigger forces a long hold
    int hold_seen;
    int hold_left;
    int run_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
            run_left     <= 0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen    <= hold_trigger;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    out_if.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    out_if.ready <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    if (run_left <= 1) begin
                        out_if.ready <= !out_if.ready;
                        run_left     <= out_if.ready ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 12);
                    end else begin
                        run_left <= run_left - 1;
                    end
                end
            endcase
        end
    end

    // monitor: predict on every accepted tick, check every accepted readout
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                pending_readouts.push_back(smooth_soc(in_if.data));
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (pending_readouts.size() == 0) begin
                    $error("readout with no tick pending: display_soc %0d", got.display_soc);
                    mismatch_count++;
                end else begin
                    want = pending_readouts.pop_front();
                    if (got.display_soc !== want.display_soc) begin
                        $error("display_soc expected %0d got %0d",
                               want.display_soc, got.display_soc);
                        mismatch_count++;
                    end
                    if (got.ocv_index !== want.ocv_index) begin
                        $error("ocv_index expected %0d got %0d",
                               want.ocv_index, got.ocv_index);
                        mismatch_count++;
                    end
                    if (got.ocv_updated !== want.ocv_updated) begin
                        $error("ocv_updated expected %0b got %0b",
                               want.ocv_updated, got.ocv_updated);
                        mismatch_count++;
                    end
                    if (got.pre_full !== want.pre_full) begin
                        $error("pre_full expected %0b got %0b",
                               want.pre_full, got.pre_full);
                        mismatch_count++;
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on stalled traffic
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("battery_soc_display_smoother verification failed");
        $finish;
    end

    initial begin
        int          phase;
        int          made;
        int          len;
        int          k;
        int          i;
        int          g;
        int          target;
        int          pick;
        bit          low_bias;
        t_scene      scene;
        t_in         t;
        logic [31:0] rtc_now;
        logic [7:0]  plan [8];

        // known values on reset and the register port from time zero
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_DEFAULT_SOC;
        cfg_if.data  = '0;
        rtc_now      = 32'd1000;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at reset settings
        @(negedge i_clk);
        // no gauge, every flag, voltage and rtc high: default reported, nothing moves
        tick_queue.push_back(mk_tick(0, 7'd77, 1, 1, 1, 1, 1, 1, 1, 16'hFFFF, '1, 1));
        // first gauge tick copies the gauge
        tick_queue.push_back(mk_tick(1, 7'd2, 0, 0, 0, 1, 0, 0, 0, 16'd4000, 32'd10, 1));
        // suspend gap of exactly the threshold, battery missing at the floor
        tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 0, 0, 0, 1, 16'd4000, 32'd480, 1));
        // five ticks just under the zero threshold let the display reach 0
        for (k = 0; k < 5; k++)
            tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 1, 0, 0, 0, 16'd3399,
                                         32'd500 + k, 1));
        // full branch while showing 0, gauge beyond 100
        tick_queue.push_back(mk_tick(1, 7'd127, 1, 1, 1, 1, 1, 0, 0, 16'd4200, 32'd600, 1));
        // voltage right at the zero threshold pulls the display back to 1
        tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 1, 0, 0, 0, 16'd3400, 32'd610, 1));
        // charging toward a gauge beyond range
        for (k = 0; k < 4; k++)
            tick_queue.push_back(mk_tick(1, 7'd127, 1, 0, 1, 1, 1, 1, 0, 16'd3900,
                                         32'd620 + k, 1));
        // full but temperature abnormal falls into the charging path
        tick_queue.push_back(mk_tick(1, 7'd127, 1, 1, 1, 1, 0, 1, 0, 16'd3900, 32'd630, 1));
        // failed rtc read while suspended, low voltage
        tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 1, 1, 0, 1, 16'd3299, 32'd5000, 0));
        // gap one short of the threshold
        tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 1, 1, 0, 1, 16'd3300, 32'd1109, 1));
        // rtc wrapped around: huge unsigned gap
        tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 1, 1, 0, 1, 16'd3300, 32'd0, 1));
        tick_queue.push_back(mk_tick(1, 7'd127, 1, 1, 1, 1, 1, 1, 1, 16'hFFFF, '1, 1));
        tick_queue.push_back(mk_tick(1, 7'd0, 0, 0, 0, 0, 0, 0, 0, 16'd0, 32'd0, 0));
        tick_queue.push_back(mk_tick(1, 7'd100, 0, 0, 0, 1, 1, 0, 0, 16'd3000, 32'd700, 1));
        wait_drained();

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: plan = '{8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                1: plan = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                2: plan = '{8'd0, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd0};
                4: plan = '{8'd50, 8'd6, 8'd3, 8'd30, 8'd15, 8'd6, 8'd4, 8'd2};
                default: begin
                    plan[0] = (phase == 3) ? 8'd101 : 8'($urandom_range(0, 255));
                    for (i = 1; i < 8; i++)
                        plan[i] = 8'($urandom_range(0, (phase == 3) ? 3 : 7));
                end
            endcase

            // register writes back to back while the pipe is empty
            @(posedge i_clk);
            for (i = 0; i < 8; i++) begin
                cfg_if.valid <= 1'b1;
                cfg_if.index <= t_cfg_idx'(i);
                cfg_if.data  <= plan[i];
                do @(posedge i_clk);
                while (!cfg_if.ready);
                case (t_cfg_idx'(i))
                    CFG_DEFAULT_SOC:         cfg_default       = plan[i][6:0];
                    CFG_UP_LIMIT_FULL:       cfg_up_full       = plan[i];
                    CFG_UP_LIMIT_CHARGING:   cfg_up_chg        = plan[i];
                    CFG_DOWN_LIMIT_AT_FULL:  cfg_down_full     = plan[i];
                    CFG_DOWN_LIMIT_HIGH:     cfg_down_high     = plan[i];
                    CFG_DOWN_LIMIT_MID:      cfg_down_mid      = plan[i];
                    CFG_DOWN_LIMIT_LOW:      cfg_down_low      = plan[i];
                    CFG_DOWN_LIMIT_LOW_VOLT: cfg_down_low_volt = plan[i];
                    default: ;
                endcase
            end
            cfg_if.valid <= 1'b0;

            @(negedge i_clk);
            rx_mode = t_rx_mode'(phase % 3);
            tx_gaps = (phase != 1 && phase != 4);

            // scenes: well-formed runs of full, charging or draining ticks,
            // plus pure noise; each run has its own gauge target
            made = 0;
            while (made < PHASE_TICKS) begin
                pick     = $urandom_range(0, 99);
                scene    = (pick < 35) ? SCN_DRAIN : (pick < 55) ? SCN_FULL :
                           (pick < 85) ? SCN_CHARGE : SCN_NOISE;
                len      = $urandom_range(10, 50);
                target   = (scene == SCN_FULL) ? $urandom_range(85, 100) :
                           (scene == SCN_DRAIN) ? $urandom_range(0, 40) :
                           $urandom_range(20, 100);
                low_bias = 1'($urandom_range(0, 1));
                for (k = 0; k < len; k++) begin
                    t = '0;
                    t.gauge_available = ($urandom_range(0, 19) != 0);
                    if ($urandom_range(0, 9) == 0) begin
                        t.gauge_soc = 7'($urandom_range(0, 127));
                    end else begin
                        g = target + int'($urandom_range(0, 4)) - 2;
                        t.gauge_soc = 7'((g < 0) ? 0 : (g > 100) ? 100 : g);
                    end
                    // rtc mostly steps slowly, sometimes jumps across the gap
                    case ($urandom_range(0, 15))
                        0:       rtc_now = rtc_now + $urandom_range(480, 5000);
                        1:       rtc_now = rtc_now + $urandom_range(479, 481);
                        2:       rtc_now = $urandom();
                        default: rtc_now = rtc_now + $urandom_range(1, 30);
                    endcase
                    t.rtc_seconds = rtc_now;
                    t.rtc_ok      = ($urandom_range(0, 9) != 0);
                    t.suspended   = ($urandom_range(0, 3) == 0);
                    case ($urandom_range(0, 7))
                        0:       t.voltage_mv = 16'($urandom());
                        1:       t.voltage_mv = 16'(($urandom_range(0, 1) ? 16'd3300
                                                                          : 16'd3400)
                                                    - $urandom_range(0, 1));
                        2, 3:    t.voltage_mv = 16'($urandom_range(2800, 3399));
                        default: t.voltage_mv = low_bias ? 16'($urandom_range(2800, 3450))
                                                         : 16'($urandom_range(3400, 4450));
                    endcase
                    t.battery_authentic = ($urandom_range(0, 7) != 0);
                    t.temp_normal       = ($urandom_range(0, 7) != 0);
                    t.battery_present   = ($urandom_range(0, 9) != 0);
                    t.is_charging       = 1'($urandom_range(0, 1));
                    t.charger_present   = 1'($urandom_range(0, 1));
                    t.battery_full      = 1'($urandom_range(0, 1));
                    case (scene)
                        SCN_FULL: begin
                            {t.charger_present, t.battery_full, t.battery_authentic,
                             t.battery_present, t.temp_normal} = 5'b11111;
                            // now and then one condition drops out
                            if ($urandom_range(0, 11) == 0)
                                {t.charger_present, t.battery_full, t.battery_authentic,
                                 t.battery_present, t.temp_normal} =
                                    5'b11111 ^ (5'b00001 << $urandom_range(0, 4));
                        end
                        SCN_CHARGE: begin
                            t.charger_present = 1'b1;
                            t.is_charging     = 1'b1;
                            t.battery_present = 1'b1;
                            t.battery_full    = ($urandom_range(0, 3) == 0);
                            if ($urandom_range(0, 11) == 0)
                                t.charger_present = 1'b0;
                        end
                        SCN_DRAIN: begin
                            t.charger_present = ($urandom_range(0, 7) == 0);
                            t.battery_full    = 1'b0;
                        end
                        default: begin
                            t.gauge_available = 1'($urandom_range(0, 1));
                            t.gauge_soc       = 7'($urandom_range(0, 127));
                            t.voltage_mv      = 16'($urandom());
                            t.rtc_seconds     = $urandom();
                            t.rtc_ok          = 1'($urandom_range(0, 1));
                            t.suspended       = 1'($urandom_range(0, 1));
                        end
                    endcase
                    tick_queue.push_back(t);
                    made++;
                end
            end

            // hold the receiver off while the sender keeps offering
            if (phase == 1 || phase == 5)
                hold_trigger = hold_trigger + 1;

            // the stimulus pauses here until every readout is back
            wait_drained();
        end

        // let any stray readout show up before the verdict
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_readouts.size() == 0) begin
            $display("battery_soc_display_smoother verification clean");
        end else begin
            $display("battery_soc_display_smoother verification failed");
        end
        $finish;
    end

endmodule
